// ===== design/gpio_interrupt_trigger_table_macros.svh =====
// Assertion macros for the GPIO interrupt trigger table checker.
// Depends on a clk in the scope of each use, and an active-low rst_n for the IMP and NXT macros.
`ifndef GPIO_INTERRUPT_TRIGGER_TABLE_MACROS_SVH
`define GPIO_INTERRUPT_TRIGGER_TABLE_MACROS_SVH

// Same-cycle implication, inactive during reset
`define GITT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gitt checker: same-cycle property failed");

// Next-cycle implication, inactive during reset
`define GITT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gitt checker: next-cycle property failed");

// Next-cycle implication that also holds across reset
`define GITT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gitt checker: reset property failed");

`endif

// ===== design/gitt_pkg.sv =====
// Shared types, command and trigger codes for the GPIO interrupt trigger table.
// No dependencies; imported by every module of the block.
`default_nettype none

package gitt_pkg;

  localparam int NUM_PINS_DEF = 64;
  localparam int PIN_W        = 8;
  localparam int MASK_W       = 64;

  // Command codes
  localparam logic [2:0] CMD_SET_LEVEL   = 3'd0;
  localparam logic [2:0] CMD_SET_KIND    = 3'd1;
  localparam logic [2:0] CMD_MASKED_KIND = 3'd2;
  localparam logic [2:0] CMD_ATTACH      = 3'd3;
  localparam logic [2:0] CMD_DETACH      = 3'd4;
  localparam logic [2:0] CMD_ENABLE      = 3'd5;
  localparam logic [2:0] CMD_DISABLE     = 3'd6;
  localparam logic [2:0] CMD_UNUSED      = 3'd7;

  // Trigger kinds; codes six and seven are stored but never fire
  localparam logic [2:0] KIND_OFF     = 3'd0;
  localparam logic [2:0] KIND_RISE    = 3'd1;
  localparam logic [2:0] KIND_FALL    = 3'd2;
  localparam logic [2:0] KIND_ANY     = 3'd3;
  localparam logic [2:0] KIND_LOW_LVL = 3'd4;
  localparam logic [2:0] KIND_HI_LVL  = 3'd5;
  localparam logic [2:0] KIND_RSVD6   = 3'd6;
  localparam logic [2:0] KIND_RSVD7   = 3'd7;

  typedef struct packed {
    logic [2:0]        command;
    logic [PIN_W-1:0]  pin;
    logic              line_level;
    logic [2:0]        trigger_kind;
    logic [MASK_W-1:0] pin_mask;
    logic              handler_present;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic             fire;
    logic [PIN_W-1:0] fire_pin;
    logic             level_now;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/gitt_pin_table.sv =====
// Per-pin state flops and single-step command evaluation.
// Depends on gitt_pkg for item types and codes.
`default_nettype none

module gitt_pin_table
  import gitt_pkg::*;
#(
  parameter int NUM_PINS = NUM_PINS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  item,
  input  wire logic      commit,
  output out_item_t      result
);

  localparam int PIN_IW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [NUM_PINS-1:0]      levels_r, levels_nxt;
  logic [NUM_PINS-1:0]      enables_r, enables_nxt;
  logic [NUM_PINS-1:0]      attached_r, attached_nxt;
  logic [NUM_PINS-1:0][2:0] kinds_r, kinds_nxt;

  logic              pin_ok;
  logic [PIN_IW-1:0] idx;
  logic              lv_old, en_old, att_old;
  logic [2:0]        kind_old;
  logic              fire_c;

  // Decide whether a pin with the given state raises its interrupt
  function automatic logic kind_fires(logic [2:0] kind, logic lv, logic changed,
                                      logic en, logic att);
    logic f;
    f = 1'b0;
    if (en && att) begin
      case (kind)
        KIND_RISE:    f = changed && lv;
        KIND_FALL:    f = changed && !lv;
        KIND_ANY:     f = changed;
        KIND_LOW_LVL: f = !lv;
        KIND_HI_LVL:  f = lv;
        default:      f = 1'b0;
      endcase
    end
    return f;
  endfunction

  // Address decode and read of the addressed pin
  assign pin_ok = ({1'b0, item.pin} < 9'(NUM_PINS));
  assign idx    = item.pin[PIN_IW-1:0];

  always_comb begin
    lv_old   = 1'b0;
    en_old   = 1'b0;
    att_old  = 1'b0;
    kind_old = KIND_OFF;
    if (pin_ok) begin
      lv_old   = levels_r[idx];
      en_old   = enables_r[idx];
      att_old  = attached_r[idx];
      kind_old = kinds_r[idx];
    end
  end

  // Apply the command to the state and evaluate the fire condition
  always_comb begin
    levels_nxt   = levels_r;
    enables_nxt  = enables_r;
    attached_nxt = attached_r;
    kinds_nxt    = kinds_r;
    fire_c       = 1'b0;
    unique case (item.command)
      CMD_MASKED_KIND: begin
        for (int i = 0; i < NUM_PINS; i++) begin
          if (item.pin_mask[i]) begin
            kinds_nxt[i] = item.trigger_kind;
            if (item.trigger_kind == KIND_OFF) enables_nxt[i] = 1'b0;
          end
        end
      end
      CMD_SET_LEVEL: begin
        if (pin_ok) begin
          levels_nxt[idx] = item.line_level;
          fire_c = kind_fires(kind_old, item.line_level, lv_old != item.line_level,
                              en_old, att_old);
        end
      end
      CMD_SET_KIND: begin
        if (pin_ok) begin
          kinds_nxt[idx] = item.trigger_kind;
          if (item.trigger_kind == KIND_OFF) enables_nxt[idx] = 1'b0;
        end
      end
      CMD_ATTACH: begin
        if (pin_ok) attached_nxt[idx] = item.handler_present;
      end
      CMD_DETACH: begin
        if (pin_ok) begin
          attached_nxt[idx] = 1'b0;
          enables_nxt[idx]  = 1'b0;
        end
      end
      CMD_ENABLE: begin
        if (pin_ok) begin
          enables_nxt[idx] = 1'b1;
          fire_c = kind_fires(kind_old, lv_old, 1'b0, 1'b1, att_old);
        end
      end
      CMD_DISABLE: begin
        if (pin_ok) enables_nxt[idx] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Form the result for the addressed pin
  always_comb begin
    result.status    = !pin_ok && (item.command != CMD_MASKED_KIND)
                       && (item.command != CMD_UNUSED);
    result.fire      = fire_c;
    result.fire_pin  = fire_c ? item.pin : '0;
    result.level_now = pin_ok && ((item.command == CMD_SET_LEVEL) ? item.line_level
                                                                  : lv_old);
  end

  // Hold the pin state; update when a command moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r   <= '0;
      enables_r  <= '0;
      attached_r <= '0;
      kinds_r    <= '0;
    end else if (commit) begin
      levels_r   <= levels_nxt;
      enables_r  <= enables_nxt;
      attached_r <= attached_nxt;
      kinds_r    <= kinds_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/gpio_interrupt_trigger_table.sv =====
// GPIO interrupt trigger table: one command per cycle, unless stalled, against per-pin flops.
// The input register holds each command, then the result register takes its result.
// Throughput: one command per cycle unless stalled, set by one pass through gitt_pin_table.
// Stall from the result side backs up through the input register to in_stall.
// Synchronous active-low reset clears all pin state (levels, enables, kinds, handlers) at once.
// Depends on gitt_pkg and gitt_pin_table.
`default_nettype none

module gpio_interrupt_trigger_table
  import gitt_pkg::*;
#(
  parameter int NUM_PINS = NUM_PINS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t result;
  logic      out_free, s1_go, in_take;

  // Pipeline flow control
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_go         = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && out_stall);

  gitt_pin_table #(
    .NUM_PINS (NUM_PINS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_data_r),
    .commit (s1_go),
    .result (result)
  );

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input transfer and the finished result
  always_ff @(posedge clk) begin
    if (in_take) s1_data_r  <= in_data;
    if (s1_go)   out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/gitt_checker.sv =====
// Port-level checker for the GPIO interrupt trigger table, bound to the top level.
// Depends on gitt_pkg and gpio_interrupt_trigger_table_macros.svh.
`default_nettype none
`include "gpio_interrupt_trigger_table_macros.svh"

module gitt_checker
  import gitt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // Stalled result holds
  `GITT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // A fire never comes with an invalid pin
  `GITT_ASSERT_IMP(a_fire_ok, out_valid && out_data.fire, !out_data.status)
  // No fire, no fire pin
  `GITT_ASSERT_IMP(a_pin_zero, out_valid && !out_data.fire, out_data.fire_pin == '0)
  // An invalid pin reports level zero
  `GITT_ASSERT_IMP(a_bad_lvl, out_valid && out_data.status, !out_data.level_now)
  // Reset empties the result register
  `GITT_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)

endmodule

bind gpio_interrupt_trigger_table gitt_checker u_gitt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
